### rtl/core/frc_pkg.sv
`timescale 1ns / 1ps

package frc_pkg;

   // Default width of the values that the block works on.
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed widths of the payload fields.
   localparam int FIELD_WIDTH = 32;
   localparam int ORDER_WIDTH = 2;

   // Codes of the order field.
   localparam logic [ORDER_WIDTH-1:0] ORDER_LESS    = 2'd0;
   localparam logic [ORDER_WIDTH-1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [ORDER_WIDTH-1:0] ORDER_GREATER = 2'd2;

endpackage

### rtl/core/frc_if.sv
`timescale 1ns / 1ps

// Request channel: two fractions.
interface frc_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [frc_pkg::FIELD_WIDTH-1:0]   num_a;
   logic signed [frc_pkg::FIELD_WIDTH-1:0]   den_a;
   logic signed [frc_pkg::FIELD_WIDTH-1:0]   num_b;
   logic signed [frc_pkg::FIELD_WIDTH-1:0]   den_b;

   modport source (output valid, num_a, den_a, num_b, den_b, input ready);
   modport sink   (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

// Response channel: the reduced fractions and their order.
interface frc_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [frc_pkg::FIELD_WIDTH-1:0]   red_num_a;
   logic signed [frc_pkg::FIELD_WIDTH-1:0]   red_den_a;
   logic signed [frc_pkg::FIELD_WIDTH-1:0]   red_num_b;
   logic signed [frc_pkg::FIELD_WIDTH-1:0]   red_den_b;
   logic [frc_pkg::ORDER_WIDTH-1:0]          order;

   modport source (output valid, red_num_a, red_den_a, red_num_b, red_den_b, order,
                   input ready);
   modport sink   (input valid, red_num_a, red_den_a, red_num_b, red_den_b, order,
                   output ready);
endinterface

### rtl/core/fraction_reduce_compare.sv
`timescale 1ns / 1ps

// Channel   Direction  Contents
// req_chan  in         num_a, den_a, num_b, den_b (low DATA_WIDTH bits used)
// rsp_chan  out        red_num_a, red_den_a, red_num_b, red_den_b, order
//
// Each Euclid step is a check state and a division; each reduction then adds
// two divisions, and the compare two multiplications; at 32 bits there are up
// to 45 Euclid steps per fraction.
// Reset is synchronous and clears the sequencer, the response valid flag and the start pulses.
// A request is taken only while the sequencer is idle; a waiting response does
// not block the next request until that request's result is ready.
module fraction_reduce_compare #(
   parameter int DATA_WIDTH = frc_pkg::DATA_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   frc_req_if.sink   req_chan,
   frc_rsp_if.source rsp_chan
);
   localparam int W  = DATA_WIDTH;
   localparam int FW = frc_pkg::FIELD_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE, S_GCD_CHK, S_GCD_WAIT, S_QN_WAIT, S_QD_WAIT,
      S_ADV, S_CMP_START, S_MA_WAIT, S_MB_WAIT, S_FINISH
   } state_type;

   state_type state_ff;

   // Working values of the current fraction and the Euclid trace.
   logic signed [W:0]     n_ff, d_ff, x_ff, y_ff, g_ff;
   logic signed [W:0]     nb_ff, db_ff;
   logic                  sel_ff;
   logic signed [W-1:0]   cur_rn_ff, cur_rd_ff;
   logic signed [W-1:0]   rn_a_ff, rd_a_ff, rn_b_ff, rd_b_ff;
   logic signed [2*W:0]   pa_ff, pb_ff;

   logic                  div_start_ff, div_busy, div_done;
   logic [W-1:0]          div_dnd_ff, div_dsr_ff, div_quot, div_rem;
   logic                  mul_start_ff, mul_done;
   logic [W-1:0]          mul_a_ff, mul_b_ff;
   logic [2*W-1:0]        mul_prod;

   logic                  rsp_valid_ff;
   logic                  rsp_load;
   logic signed [FW-1:0]  out_na_ff, out_da_ff, out_nb_ff, out_db_ff;
   logic [frc_pkg::ORDER_WIDTH-1:0] out_ord_ff;

   logic signed [W:0]     na_n, da_n, nb_n, db_n;

   function automatic logic [W-1:0] mag(input logic signed [W:0] v);
      logic signed [W:0] t;
      t = (v < 0) ? -v : v;
      return t[W-1:0];
   endfunction

   function automatic logic signed [W:0] with_sign(input logic [W-1:0] m,
                                                   input logic neg);
      logic signed [W:0] t;
      t = signed'({1'b0, m});
      return neg ? -t : t;
   endfunction

   function automatic logic signed [W:0] ext(input logic [FW-1:0] v);
      return signed'({v[W-1], v[W-1:0]});
   endfunction

   frc_div #(.DATA_WIDTH(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_dnd_ff),
      .divisor   (div_dsr_ff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   frc_mul #(.DATA_WIDTH(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mcand   (mul_a_ff),
      .mplier  (mul_b_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Denominators made positive by negating both parts of each fraction.
   always_comb begin
      na_n = (rd_a_ff < 0) ? -(W+1)'(rn_a_ff) : (W+1)'(rn_a_ff);
      da_n = (rd_a_ff < 0) ? -(W+1)'(rd_a_ff) : (W+1)'(rd_a_ff);
      nb_n = (rd_b_ff < 0) ? -(W+1)'(rn_b_ff) : (W+1)'(rn_b_ff);
      db_n = (rd_b_ff < 0) ? -(W+1)'(rd_b_ff) : (W+1)'(rd_b_ff);
   end

   // The output register takes a new result once the previous one has gone.
   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // Sequencer: Euclid and the reductions on the divider, then the cross products.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
      end else begin
         // Start pulses for the shared divider and multiplier.
         div_start_ff <= ((state_ff == S_GCD_CHK) && ((y_ff != 0) || (x_ff != 0)))
                         || ((state_ff == S_QN_WAIT) && div_done);
         mul_start_ff <= (state_ff == S_CMP_START)
                         || ((state_ff == S_MA_WAIT) && mul_done);
         // The response stays valid until its transfer.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  n_ff     <= ext(req_chan.num_a);
                  d_ff     <= ext(req_chan.den_a);
                  x_ff     <= ext(req_chan.num_a);
                  y_ff     <= ext(req_chan.den_a);
                  nb_ff    <= ext(req_chan.num_b);
                  db_ff    <= ext(req_chan.den_b);
                  sel_ff   <= 1'b0;
                  state_ff <= S_GCD_CHK;
               end
            end
            S_GCD_CHK: begin
               if (y_ff == 0) begin
                  g_ff <= x_ff;
                  if (x_ff == 0) begin
                     cur_rn_ff <= n_ff[W-1:0];
                     cur_rd_ff <= d_ff[W-1:0];
                     state_ff  <= S_ADV;
                  end else begin
                     div_dnd_ff <= mag(n_ff);
                     div_dsr_ff <= mag(x_ff);
                     state_ff   <= S_QN_WAIT;
                  end
               end else begin
                  div_dnd_ff <= mag(x_ff);
                  div_dsr_ff <= mag(y_ff);
                  state_ff   <= S_GCD_WAIT;
               end
            end
            S_GCD_WAIT: begin
               if (div_done) begin
                  x_ff     <= y_ff;
                  y_ff     <= with_sign(div_rem, x_ff < 0);
                  state_ff <= S_GCD_CHK;
               end
            end
            S_QN_WAIT: begin
               if (div_done) begin
                  cur_rn_ff  <= W'(with_sign(div_quot, (n_ff < 0) ^ (g_ff < 0)));
                  div_dnd_ff <= mag(d_ff);
                  div_dsr_ff <= mag(g_ff);
                  state_ff   <= S_QD_WAIT;
               end
            end
            S_QD_WAIT: begin
               if (div_done) begin
                  cur_rd_ff <= W'(with_sign(div_quot, (d_ff < 0) ^ (g_ff < 0)));
                  state_ff  <= S_ADV;
               end
            end
            S_ADV: begin
               if (!sel_ff) begin
                  rn_a_ff  <= cur_rn_ff;
                  rd_a_ff  <= cur_rd_ff;
                  n_ff     <= nb_ff;
                  d_ff     <= db_ff;
                  x_ff     <= nb_ff;
                  y_ff     <= db_ff;
                  sel_ff   <= 1'b1;
                  state_ff <= S_GCD_CHK;
               end else begin
                  rn_b_ff  <= cur_rn_ff;
                  rd_b_ff  <= cur_rd_ff;
                  state_ff <= S_CMP_START;
               end
            end
            S_CMP_START: begin
               mul_a_ff <= mag(na_n);
               mul_b_ff <= db_n[W-1:0];
               state_ff <= S_MA_WAIT;
            end
            S_MA_WAIT: begin
               if (mul_done) begin
                  pa_ff    <= (na_n < 0) ? -signed'({1'b0, mul_prod})
                                         : signed'({1'b0, mul_prod});
                  mul_a_ff <= mag(nb_n);
                  mul_b_ff <= da_n[W-1:0];
                  state_ff <= S_MB_WAIT;
               end
            end
            S_MB_WAIT: begin
               if (mul_done) begin
                  pb_ff    <= (nb_n < 0) ? -signed'({1'b0, mul_prod})
                                         : signed'({1'b0, mul_prod});
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // Load the output register once the previous response has gone.
               if (rsp_load) begin
                  out_na_ff <= FW'(rn_a_ff);
                  out_da_ff <= FW'(rd_a_ff);
                  out_nb_ff <= FW'(rn_b_ff);
                  out_db_ff <= FW'(rd_b_ff);
                  if (pa_ff < pb_ff) begin
                     out_ord_ff <= frc_pkg::ORDER_LESS;
                  end else if (pa_ff > pb_ff) begin
                     out_ord_ff <= frc_pkg::ORDER_GREATER;
                  end else begin
                     out_ord_ff <= frc_pkg::ORDER_EQUAL;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red_num_a = out_na_ff;
   assign rsp_chan.red_den_a = out_da_ff;
   assign rsp_chan.red_num_b = out_nb_ff;
   assign rsp_chan.red_den_b = out_db_ff;
   assign rsp_chan.order     = out_ord_ff;

   // The divider is never restarted while a division is in flight.
   assert property (@(posedge clock) disable iff (reset) div_start_ff |-> !div_busy)
      else $error("divider started while busy");

   // Euclid and the reductions never divide by zero.
   assert property (@(posedge clock) disable iff (reset) div_start_ff |-> div_dsr_ff != 0)
      else $error("division by zero issued");

   // After a request transfer the block is busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
                    (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while busy");
endmodule

### rtl/core/frc_div.sv
`timescale 1ns / 1ps

// Restoring divider on unsigned magnitudes, one quotient bit per cycle.
module frc_div #(
   parameter int DATA_WIDTH = frc_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);
   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quot_ff, quot_in;
   logic [W-1:0]  dsr_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [W:0]    rem_sh;

   // One trial subtraction per cycle.
   always_comb begin
      rem_sh = {rem_ff[W-1:0], quot_ff[W-1]};
      if (rem_sh >= {1'b0, dsr_ff}) begin
         rem_in  = rem_sh - {1'b0, dsr_ff};
         quot_in = {quot_ff[W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         quot_in = {quot_ff[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         rem_ff  <= '0;
         quot_ff <= dividend;
         dsr_ff  <= divisor;
         cnt_ff  <= CW'(W);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CW'(1));
         done_ff <= (cnt_ff == CW'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff[W-1:0];
endmodule

### rtl/core/frc_mul.sv
`timescale 1ns / 1ps

// Shift-and-add multiplier on unsigned magnitudes, one multiplier bit per cycle.
module frc_mul #(
   parameter int DATA_WIDTH = frc_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DATA_WIDTH-1:0]   mcand,
   input  logic [DATA_WIDTH-1:0]   mplier,
   output logic                    done,
   output logic [2*DATA_WIDTH-1:0] product
);
   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [2*W-1:0] acc_ff;
   logic [2*W-1:0] mcd_ff;
   logic [W-1:0]   mpl_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         acc_ff  <= '0;
         mcd_ff  <= {{W{1'b0}}, mcand};
         mpl_ff  <= mplier;
         cnt_ff  <= CW'(W);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (mpl_ff[0]) begin
            acc_ff <= acc_ff + mcd_ff;
         end
         mcd_ff  <= {mcd_ff[2*W-2:0], 1'b0};
         mpl_ff  <= {1'b0, mpl_ff[W-1:1]};
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CW'(1));
         done_ff <= (cnt_ff == CW'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

### test/frc_tb_pkg.sv
`timescale 1ns / 1ps

// Shared types of the testbench: one request and one response transfer.
package frc_tb_pkg;

   typedef struct packed {
      logic signed [frc_pkg::FIELD_WIDTH-1:0] num_a;
      logic signed [frc_pkg::FIELD_WIDTH-1:0] den_a;
      logic signed [frc_pkg::FIELD_WIDTH-1:0] num_b;
      logic signed [frc_pkg::FIELD_WIDTH-1:0] den_b;
   } fraction_pair_type;

   typedef struct packed {
      logic signed [frc_pkg::FIELD_WIDTH-1:0] red_num_a;
      logic signed [frc_pkg::FIELD_WIDTH-1:0] red_den_a;
      logic signed [frc_pkg::FIELD_WIDTH-1:0] red_num_b;
      logic signed [frc_pkg::FIELD_WIDTH-1:0] red_den_b;
      logic [frc_pkg::ORDER_WIDTH-1:0]        order;
   } reduced_pair_type;
endpackage

### test/frc_checker.sv
`timescale 1ns / 1ps

// Watches both channels, works out the reduced fractions of each request
// transfer and compares every response transfer with the oldest one waiting.
module frc_checker (
   input  logic          clock,
   input  logic          reset,
   frc_req_if            req,
   frc_rsp_if            rsp,
   output int            fail_count,
   output int            pending_count
);
   frc_tb_pkg::reduced_pair_type expected_q[$];

   // Euclid with truncating remainder; the sign follows the trace.
   function automatic longint trunc_gcd(longint x, longint y);
      longint r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // Reduce one fraction and wrap the parts back to 32 bits.
   function automatic void reduce_fraction(input longint n, input longint d,
                                           output longint rn, output longint rd);
      longint g;
      g = trunc_gcd(n, d);
      if (g != 0) begin
         n = n / g;
         d = d / g;
      end
      rn = longint'(signed'(n[31:0]));
      rd = longint'(signed'(d[31:0]));
   endfunction

   function automatic frc_tb_pkg::reduced_pair_type reduce_and_order(
         frc_tb_pkg::fraction_pair_type p);
      frc_tb_pkg::reduced_pair_type e;
      longint na, da, nb, db, cross_a, cross_b;
      reduce_fraction(longint'(p.num_a), longint'(p.den_a), na, da);
      reduce_fraction(longint'(p.num_b), longint'(p.den_b), nb, db);
      e.red_num_a = na[31:0];
      e.red_den_a = da[31:0];
      e.red_num_b = nb[31:0];
      e.red_den_b = db[31:0];
      // Make both denominators positive before the exact cross products.
      if (da < 0) begin
         na = -na;
         da = -da;
      end
      if (db < 0) begin
         nb = -nb;
         db = -db;
      end
      cross_a = na * db;
      cross_b = nb * da;
      if (cross_a < cross_b) e.order = frc_pkg::ORDER_LESS;
      else if (cross_a > cross_b) e.order = frc_pkg::ORDER_GREATER;
      else e.order = frc_pkg::ORDER_EQUAL;
      return e;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      frc_tb_pkg::reduced_pair_type e;
      if (reset) begin
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (req.valid && req.ready)
            expected_q.push_back(reduce_and_order({req.num_a, req.den_a,
                                                   req.num_b, req.den_b}));
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response transfer with nothing expected", $time);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e !== {rsp.red_num_a, rsp.red_den_a, rsp.red_num_b,
                          rsp.red_den_b, rsp.order}) begin
                  $display({"%0t: expected %0d/%0d %0d/%0d order %0d, ",
                            "got %0d/%0d %0d/%0d order %0d"},
                           $time, e.red_num_a, e.red_den_a, e.red_num_b, e.red_den_b,
                           e.order, rsp.red_num_a, rsp.red_den_a, rsp.red_num_b,
                           rsp.red_den_b, rsp.order);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   localparam int RANDOM_ITEMS = 180;
   localparam longint CYCLE_LIMIT = 8000000;
   localparam int HOLD_CYCLES = 12000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   longint cycle_count;
   bit   hold_off;
   bit   hold_go;
   bit   no_idle;

   frc_req_if req_chan ();
   frc_rsp_if rsp_chan ();

   fraction_reduce_compare dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   frc_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Long receiver hold-off, counted here while the sender keeps offering.
   initial begin
      hold_off = 1'b0;
      wait (hold_go);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // Receiver: random stalls, or a long hold-off while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (hold_off) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= no_idle || ($urandom_range(99) >= 18);
   end

   // A random value biased towards the interesting extremes.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000001;
         2: return 32'sh80000000;
         3: return 32'($signed($urandom_range(20)) - 10);
         4: return $urandom & 32'h0000ffff;
         5: return $urandom | 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request and hold it until the transfer.
   task automatic send_pair(logic [31:0] na, logic [31:0] da,
                            logic [31:0] nb, logic [31:0] db);
      while (!no_idle && $urandom_range(99) < 18) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.num_a <= na;
      req_chan.den_a <= da;
      req_chan.num_b <= nb;
      req_chan.den_b <= db;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Directed cases, then random pairs.
   initial begin
      logic [31:0] a, b, s;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.num_a = '0;
      req_chan.den_a = 32'd1;
      req_chan.num_b = '0;
      req_chan.den_b = 32'd1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_pair(32'd0, 32'd5, 32'd0, -32'sd7);
      send_pair(32'sh80000000, -32'sd1, 32'sh80000000, 32'sh80000000);
      send_pair(32'd6, 32'd0, 32'd0, 32'd0);
      send_pair(32'd0, 32'd0, -32'sd4, 32'd0);
      send_pair(32'sh7fffffff, 32'sh80000001, 32'sh80000001, 32'sh7fffffff);
      send_pair(32'sh7fffffff, 32'd1, 32'sh80000000, 32'd1);
      send_pair(32'd6, -32'sd4, -32'sd3, 32'd2);
      send_pair(32'd2, 32'd3, 32'd3, 32'd4);
      send_pair(32'd3, 32'd4, 32'd2, 32'd3);
      send_pair(-32'sd12, -32'sd18, 32'd2, 32'd3);
      send_pair(32'hffffffff, 32'hffffffff, 32'd1, 32'd1);
      send_pair(32'sh80000000, 32'sh7fffffff, 32'd0, 32'sh80000000);
      send_pair(32'd1836311903, 32'd1134903170, 32'd514229, 32'd317811);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Stretch with no idling, and one long receiver hold-off.
         no_idle = (i >= 40 && i < 70);
         if (i == 100) hold_go = 1'b1;
         a = pick_value();
         b = pick_value();
         s = 32'($urandom_range(1, 500));
         case ($urandom_range(3))
            0: send_pair(a, b, a, b);
            1: send_pair(a, b, a * s, b * s);
            default: send_pair(a, b, pick_value(), pick_value());
         endcase
      end
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

### fraction_reduce_compare.f
rtl/core/frc_pkg.sv
rtl/core/frc_if.sv
rtl/core/frc_div.sv
rtl/core/frc_mul.sv
rtl/core/fraction_reduce_compare.sv
test/frc_tb_pkg.sv
test/frc_checker.sv
test/tb.sv
